FILE: hdl/skct_pkg.sv
// Shared types and constants for the sorted key and CRC tracker.
// Used by the table memory, the sequencer and the top level.
package skct_pkg;

   localparam int KEY_W = 16;
   localparam int CRC_W = 32;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CRC_W-1:0] crc;
   } entry_type;

endpackage

FILE: hdl/skct_table.sv
// Entry memory of the tracker: one key and CRC per word.
// One write port and one read port with registered read data; depends on skct_pkg.
module skct_table import skct_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int IDX_W    = 6
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/skct_ctrl.sv
// Sequencer of the tracker: binary search with one shared key compare, then
// an update, a reject or an insert that moves entries up one word at a time.
// Drives the skct_table ports; depends on skct_pkg.
module skct_ctrl import skct_pkg::*; #(
   parameter int CAPACITY = 64,
   parameter int IDX_W    = 6,
   parameter int CNT_W    = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_kind,
   input  logic [KEY_W-1:0] req_program_key,
   input  logic [CRC_W-1:0] req_crc_value,
   output logic             rsp_strobe,
   output logic             rsp_key_present,
   output logic             rsp_crc_equal,
   output logic             rsp_full_reject,
   output logic             rd_en,
   output logic [IDX_W-1:0] rd_addr,
   input  entry_type        rd_data,
   output logic             wr_en,
   output logic [IDX_W-1:0] wr_addr,
   output entry_type        wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SRCH  = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_SHWR  = 3'd4;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             kind_ff, kind_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CRC_W-1:0] crc_ff, crc_in;
   logic             hit_ff, hit_in;
   logic [CRC_W-1:0] old_crc_ff, old_crc_in;
   logic             strobe_ff, strobe_in;
   logic             present_ff, present_in;
   logic             equal_ff, equal_in;
   logic             reject_ff, reject_in;

   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic [CNT_W-1:0] idx_dec;
   logic             key_less;
   logic             key_same;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[IDX_W:1];
   assign idx_dec  = idx_ff - CNT_W'(1);
   assign key_less = rd_data.key < key_ff;
   assign key_same = rd_data.key == key_ff;

   always_comb begin
      state_in   = state_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      crc_in     = crc_ff;
      hit_in     = hit_ff;
      old_crc_in = old_crc_ff;
      strobe_in  = 1'b0;
      present_in = present_ff;
      equal_in   = equal_ff;
      reject_in  = reject_ff;
      rd_en      = 1'b0;
      rd_addr    = mid;
      wr_en      = 1'b0;
      wr_addr    = lo_ff[IDX_W-1:0];
      wr_data    = '{key: key_ff, crc: crc_ff};
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               key_in   = req_program_key;
               crc_in   = req_crc_value;
               lo_in    = '0;
               hi_in    = count_ff;
               hit_in   = 1'b0;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               state_in = ST_CMP;
            end else begin
               present_in = hit_ff;
               equal_in   = hit_ff && (old_crc_ff == crc_ff);
               reject_in  = 1'b0;
               if (kind_ff == KIND_CHECK) begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else if (hit_ff) begin
                  wr_en     = 1'b1;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else if (count_ff == CAP_CNT) begin
                  reject_in = 1'b1;
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in   = count_ff;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_CMP: begin
            if (key_less) begin
               lo_in = CNT_W'(mid) + CNT_W'(1);
            end else begin
               hi_in = CNT_W'(mid);
            end
            if (key_same) begin
               hit_in     = 1'b1;
               old_crc_in = rd_data.crc;
            end
            state_in = ST_SRCH;
         end
         ST_SHIFT: begin
            if (idx_ff > lo_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_dec[IDX_W-1:0];
               state_in = ST_SHWR;
            end else begin
               wr_en     = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SHWR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[IDX_W-1:0];
            wr_data  = rd_data;
            idx_in   = idx_dec;
            state_in = ST_SHIFT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      idx_ff     <= idx_in;
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      crc_ff     <= crc_in;
      hit_ff     <= hit_in;
      old_crc_ff <= old_crc_in;
      present_ff <= present_in;
      equal_ff   <= equal_in;
      reject_ff  <= reject_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_strobe      = strobe_ff;
   assign rsp_key_present = present_ff;
   assign rsp_crc_equal   = equal_ff;
   assign rsp_full_reject = reject_ff;

endmodule

FILE: hdl/sorted_key_crc_tracker.sv
// Top level of the sorted key and CRC tracker.
// Instantiates skct_ctrl and skct_table; depends on skct_pkg.
//
// The block keeps up to CAPACITY entries sorted by a 16-bit key, each with a
// 32-bit CRC. An item is taken at a rising edge with start high and busy low.
// An add (kind 0) updates the CRC of a present key or inserts a new key at its
// sorted place; a check (kind 1) only looks the key up. Every item gives one
// result, shown for a single cycle with rsp_strobe high, in the first cycle
// with busy low. The receiver cannot stall and must take it then.
// Each step of the binary search over the n stored entries reads the middle
// entry from memory (state SRCH) and compares its key (state CMP), halving the
// range; a check, an update or a reject (an add of a new key to a full table)
// then shows its result. An insert at position p then moves each of the n - p
// later entries up one word through the single memory port pair. The next
// item can be taken in the cycle of the result strobe.
// Reset (synchronous) empties the table and clears the result strobe; the
// memory is not cleared, since only entries below the count are read.
module sorted_key_crc_tracker import skct_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_kind,
   input  logic [KEY_W-1:0] req_program_key,
   input  logic [CRC_W-1:0] req_crc_value,
   output logic             rsp_strobe,
   output logic             rsp_key_present,
   output logic             rsp_crc_equal,
   output logic             rsp_full_reject
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   skct_ctrl #(
      .CAPACITY(CAPACITY),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_program_key(req_program_key),
      .req_crc_value  (req_crc_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_key_present(rsp_key_present),
      .rsp_crc_equal  (rsp_crc_equal),
      .rsp_full_reject(rsp_full_reject),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

   skct_table #(
      .CAPACITY(CAPACITY),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

endmodule

FILE: hdl/skct_check.sv
// Port-level checker for the sorted key and CRC tracker, with its bind.
// Depends on skct_pkg and the top level sorted_key_crc_tracker.
module skct_check import skct_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input logic             rsp_key_present,
   input logic             rsp_crc_equal,
   input logic             rsp_full_reject
);

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Block did not go busy after taking an item.");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Result shown while the block is still busy.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for more than one cycle.");

   a_equal_needs_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_crc_equal) |-> rsp_key_present)
      else $error("CRC match reported for a key that is not present.");

   a_reject_new_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_full_reject) |-> (!rsp_key_present && !rsp_crc_equal))
      else $error("Full reject reported for a key that is present.");

endmodule

bind sorted_key_crc_tracker skct_check u_skct_check (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for the sorted key and CRC tracker.
// Drives add and check items and predicts every result from its own copy of the table.
// Depends on skct_pkg and on sorted_key_crc_tracker.
`timescale 1ns / 1ps

module tb_top;
   import skct_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int QUIET_FIRST = 200;
   localparam int QUIET_LAST = 350;

   typedef struct {
      logic             kind;
      logic [KEY_W-1:0] key;
      logic [CRC_W-1:0] crc;
      bit               wait_idle;
   } table_item_type;

   typedef struct {
      logic present;
      logic equal;
      logic reject;
   } lookup_status_type;

   logic             clock;
   logic             reset;
   logic             start = 1'b0;
   logic             busy;
   logic             req_kind = KIND_ADD;
   logic [KEY_W-1:0] req_program_key = '0;
   logic [CRC_W-1:0] req_crc_value = '0;
   logic             rsp_strobe;
   logic             rsp_key_present;
   logic             rsp_crc_equal;
   logic             rsp_full_reject;

   table_item_type    pending_items[$];
   table_item_type    active_item;
   lookup_status_type expected_status[$];
   lookup_status_type seen_status;

   logic [KEY_W-1:0] model_keys[TABLE_DEPTH];
   logic [CRC_W-1:0] model_crcs[TABLE_DEPTH];
   int               model_count = 0;

   logic [CRC_W-1:0] plan_crcs[logic [KEY_W-1:0]];
   logic [KEY_W-1:0] plan_keys[$];

   int               accepted_items = 0;
   int               strobes_seen = 0;
   int               presented_items = 0;
   int               checked_items = 0;
   int               mismatch_count = 0;

   sorted_key_crc_tracker #(
      .CAPACITY(TABLE_DEPTH)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_program_key(req_program_key),
      .req_crc_value  (req_crc_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_key_present(rsp_key_present),
      .rsp_crc_equal  (rsp_crc_equal),
      .rsp_full_reject(rsp_full_reject)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Looks the key up in the sorted table, then applies an add the way the block should.
   function automatic lookup_status_type apply_item(table_item_type item);
      lookup_status_type st;
      int                lo;
      int                hi;
      int                mid;
      int                pos;
      int                i;
      st = '{present: 1'b0, equal: 1'b0, reject: 1'b0};
      lo = 0;
      hi = model_count;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (model_keys[mid] < item.key) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      pos = lo;
      st.present = (pos < model_count) && (model_keys[pos] == item.key);
      if (st.present) begin
         st.equal = (model_crcs[pos] == item.crc);
      end
      if (item.kind == KIND_ADD) begin
         if (st.present) begin
            model_crcs[pos] = item.crc;
         end else if (model_count >= TABLE_DEPTH) begin
            st.reject = 1'b1;
         end else begin
            for (i = model_count; i > pos; i--) begin
               model_keys[i] = model_keys[i - 1];
               model_crcs[i] = model_crcs[i - 1];
            end
            model_keys[pos] = item.key;
            model_crcs[pos] = item.crc;
            model_count++;
         end
      end
      return st;
   endfunction

   // Queues an item and tracks which keys the stimulus has put in the table so far.
   function automatic void plan_item(logic kind, logic [KEY_W-1:0] key,
                                     logic [CRC_W-1:0] crc, bit wait_idle);
      pending_items.push_back('{kind: kind, key: key, crc: crc, wait_idle: wait_idle});
      if (kind == KIND_ADD) begin
         if (plan_crcs.exists(key)) begin
            plan_crcs[key] = crc;
         end else if (plan_keys.size() < TABLE_DEPTH) begin
            plan_crcs[key] = crc;
            plan_keys.push_back(key);
         end
      end
   endfunction

   function automatic logic [CRC_W-1:0] pick_crc();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return '0;
      end else if (roll < 20) begin
         return '1;
      end
      return $urandom;
   endfunction

   function automatic logic [KEY_W-1:0] pick_stored_key();
      return plan_keys[$urandom_range(0, plan_keys.size() - 1)];
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] item %0d: %s", $realtime, checked_items, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            strobes_seen++;
         end
         if (start && !busy) begin
            expected_status.push_back(apply_item(active_item));
            accepted_items++;
         end
         if (!(start && busy)) begin
            if (pending_items.size() != 0
                && !(pending_items[0].wait_idle && accepted_items != strobes_seen)
                && !($urandom_range(0, 99) < 12
                     && !(presented_items >= QUIET_FIRST && presented_items < QUIET_LAST)))
            begin
               active_item = pending_items.pop_front();
               presented_items++;
               start <= 1'b1;
               req_kind <= active_item.kind;
               req_program_key <= active_item.key;
               req_crc_value <= active_item.crc;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         checked_items++;
         if (expected_status.size() == 0) begin
            report_mismatch("result strobe with no item outstanding");
         end else begin
            seen_status = expected_status.pop_front();
            if (rsp_key_present !== seen_status.present) begin
               report_mismatch($sformatf("key_present %b, predicted %b",
                                         rsp_key_present, seen_status.present));
            end
            if (rsp_crc_equal !== seen_status.equal) begin
               report_mismatch($sformatf("crc_equal %b, predicted %b",
                                         rsp_crc_equal, seen_status.equal));
            end
            if (rsp_full_reject !== seen_status.reject) begin
               report_mismatch($sformatf("full_reject %b, predicted %b",
                                         rsp_full_reject, seen_status.reject));
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      int               roll;
      logic [KEY_W-1:0] key;
      logic             kind;

      plan_item(KIND_CHECK, 16'h0000, 32'h0000_0000, 1'b0);
      plan_item(KIND_ADD,   16'h8000, 32'hFFFF_FFFF, 1'b0);
      plan_item(KIND_ADD,   16'h0000, 32'h0000_0000, 1'b0);
      plan_item(KIND_ADD,   16'hFFFF, 32'hA5A5_A5A5, 1'b0);
      plan_item(KIND_ADD,   16'h7FFF, 32'h5A5A_5A5A, 1'b0);
      plan_item(KIND_CHECK, 16'h8000, 32'hFFFF_FFFF, 1'b0);
      plan_item(KIND_CHECK, 16'h8000, 32'hFFFF_FFFE, 1'b0);
      plan_item(KIND_CHECK, 16'h8001, 32'hFFFF_FFFF, 1'b0);
      plan_item(KIND_ADD,   16'h8000, 32'h1234_5678, 1'b0);
      plan_item(KIND_ADD,   16'h8000, 32'h1234_5678, 1'b0);
      plan_item(KIND_CHECK, 16'hFFFF, 32'hA5A5_A5A5, 1'b0);
      plan_item(KIND_CHECK, 16'h0000, 32'h0000_0000, 1'b0);
      plan_item(KIND_CHECK, 16'h0001, 32'h0000_0000, 1'b0);
      plan_item(KIND_CHECK, 16'hFFFE, 32'hA5A5_A5A5, 1'b0);
      plan_item(KIND_CHECK, 16'h7FFF, 32'h0000_0000, 1'b0);
      plan_item(KIND_ADD,   16'h0001, 32'hFFFF_FFFF, 1'b0);
      plan_item(KIND_ADD,   16'hFFFE, 32'h0000_0001, 1'b0);

      for (int n = 0; n < 650; n++) begin
         roll = $urandom_range(0, 99);
         kind = KIND_ADD;
         key = KEY_W'($urandom);
         if (plan_keys.size() != 0 && roll >= 35 && roll < 85) begin
            key = pick_stored_key();
            if (roll >= 50) begin
               kind = KIND_CHECK;
            end
            if (roll >= 75) begin
               kind = $urandom_range(0, 1) ? KIND_CHECK : KIND_ADD;
               key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
            end
         end else if (roll >= 85) begin
            kind = $urandom_range(0, 1) ? KIND_CHECK : KIND_ADD;
         end
         if (plan_crcs.exists(key) && $urandom_range(0, 99) < 50) begin
            plan_item(kind, key, plan_crcs[key], n == 0 || n == 300 || n == 500);
         end else begin
            plan_item(kind, key, pick_crc(), n == 0 || n == 300 || n == 500);
         end
      end

      @(negedge reset);
      while (pending_items.size() != 0 || start) begin
         @(posedge clock);
      end
      while (expected_status.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/skct_pkg.sv
hdl/skct_table.sv
hdl/skct_ctrl.sv
hdl/sorted_key_crc_tracker.sv
hdl/skct_check.sv
tb/tb_top.sv
